/* design/hpt_pkg.sv */
// Package for the homography point transform: coordinate and fixed-point
// widths, coefficient register indexes, status codes and channel payload types.
// No dependencies.
package hpt_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 32;
	localparam int COEF_W     = 48;
	localparam int NUM_COEFS  = 8;
	localparam int SCR_W      = 16;

	typedef enum logic [2:0] {
		COEF_XX = 3'd0,
		COEF_XY = 3'd1,
		COEF_XT = 3'd2,
		COEF_YX = 3'd3,
		COEF_YY = 3'd4,
		COEF_YT = 3'd5,
		COEF_WX = 3'd6,
		COEF_WY = 3'd7
	} coef_idx_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] cam_x;
		logic [COORD_BITS-1:0] cam_y;
	} point_in_t;

	typedef struct packed {
		logic signed [SCR_W-1:0] screen_x;
		logic signed [SCR_W-1:0] screen_y;
		logic [1:0]              status;
	} point_out_t;

endpackage

/* design/homography_point_transform.sv */
// Pipelined planar homography: camera point in, screen point out.
// Multiply, two add stages, magnitude stage, an 18-step restoring divider and
// a saturation stage. Depends on hpt_pkg.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------
//  in      | in_valid/in_ready   | in_data   (cam_x, cam_y)
//  out     | out_valid/out_ready | out_data  (screen_x, screen_y, status)
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data (48-bit coefficient)
//
// One transaction per cycle while the output is not stalled; each point passes
// through the four arithmetic stages, the eighteen divider steps and the output
// stage. The whole pipeline advances together and holds in place while a
// finished result waits at the output, so in_ready is low exactly then.
// Reset clears every valid bit and loads the identity matrix; cfg_ready is
// always high.
module homography_point_transform import hpt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  point_in_t  in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output point_out_t out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  coef_idx_t  cfg_index,
	input  logic [COEF_W-1:0] cfg_data
);

	localparam int PROD_W = COEF_W + COORD_BITS + 1;
	localparam int SUM_W  = COEF_W + COORD_BITS + 2;
	localparam int MAG_W  = SUM_W - 1;
	localparam int QW     = SCR_W + 2;
	localparam int DIV_W  = MAG_W + QW - 1;
	localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(64'd1 << FRAC_BITS);
	localparam logic signed [SUM_W-1:0]  W_ONE    = SUM_W'(64'd1 << FRAC_BITS);
	localparam logic [QW-1:0] POS_MAX = QW'((64'd1 << (SCR_W - 1)) - 64'd1);
	localparam logic [QW-1:0] NEG_MAX = QW'(64'd1 << (SCR_W - 1));
	localparam logic signed [SCR_W-1:0] SCR_HI = SCR_W'(POS_MAX);
	localparam logic signed [SCR_W-1:0] SCR_LO = SCR_W'(NEG_MAX);

	function automatic logic [MAG_W:0] div_step(input logic [MAG_W-1:0] r,
			input logic [MAG_W-1:0] d, input int sh);
		logic [DIV_W-1:0] dsh;
		logic [DIV_W-1:0] rw;
		logic             ge;
		dsh = DIV_W'(d) << sh;
		rw  = DIV_W'(r);
		ge  = (rw >= dsh);
		return {ge, ge ? MAG_W'(rw - dsh) : r};
	endfunction

	function automatic logic [SCR_W:0] sat_quot(input logic [QW-1:0] q, input logic neg);
		logic [SCR_W-1:0] v;
		logic             sat;
		sat = 1'b0;
		if (!neg) begin
			if (q > POS_MAX) begin
				v   = SCR_HI;
				sat = 1'b1;
			end else begin
				v = q[SCR_W-1:0];
			end
		end else begin
			if (q > NEG_MAX) begin
				v   = SCR_LO;
				sat = 1'b1;
			end else begin
				v = SCR_W'(-q);
			end
		end
		return {sat, v};
	endfunction

	logic signed [COEF_W-1:0] coef_q [NUM_COEFS];
	logic adv;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s23;
	logic signed [PROD_W-1:0] pxx_s1, pxy_s1, pyx_s1, pyy_s1, pwx_s1, pwy_s1;
	logic signed [SUM_W-1:0]  nx_s2, ny_s2, w_s2;
	logic signed [SUM_W-1:0]  nx_s3, ny_s3, w_s3;
	logic [MAG_W-1:0] nx_s4, ny_s4, w_s4;
	logic negx_s4, negy_s4, zero_s4;

	logic [QW-1:0]    dv_vld_s;
	logic [MAG_W-1:0] rx_s [QW];
	logic [MAG_W-1:0] ry_s [QW];
	logic [MAG_W-1:0] den_s [QW];
	logic [QW-1:0]    qx_s [QW];
	logic [QW-1:0]    qy_s [QW];
	logic [QW-1:0]    negx_s, negy_s, zero_s;

	point_out_t res_s23;
	point_out_t res_d;
	logic [SCR_W:0] fx, fy;

	assign adv       = !vld_s23 || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;
	assign out_valid = vld_s23;
	assign out_data  = res_s23;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++) begin
				coef_q[i] <= (i == COEF_XX || i == COEF_YY) ? COEF_ONE : '0;
			end
		end else if (cfg_valid) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s23 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s23 <= dv_vld_s[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pxx_s1 <= PROD_W'(coef_q[COEF_XX]) * PROD_W'($signed({1'b0, in_data.cam_x}));
			pxy_s1 <= PROD_W'(coef_q[COEF_XY]) * PROD_W'($signed({1'b0, in_data.cam_y}));
			pyx_s1 <= PROD_W'(coef_q[COEF_YX]) * PROD_W'($signed({1'b0, in_data.cam_x}));
			pyy_s1 <= PROD_W'(coef_q[COEF_YY]) * PROD_W'($signed({1'b0, in_data.cam_y}));
			pwx_s1 <= PROD_W'(coef_q[COEF_WX]) * PROD_W'($signed({1'b0, in_data.cam_x}));
			pwy_s1 <= PROD_W'(coef_q[COEF_WY]) * PROD_W'($signed({1'b0, in_data.cam_y}));

			nx_s2 <= SUM_W'(pxx_s1) + SUM_W'(pxy_s1);
			ny_s2 <= SUM_W'(pyx_s1) + SUM_W'(pyy_s1);
			w_s2  <= SUM_W'(pwx_s1) + SUM_W'(pwy_s1);

			nx_s3 <= nx_s2 + SUM_W'(coef_q[COEF_XT]);
			ny_s3 <= ny_s2 + SUM_W'(coef_q[COEF_YT]);
			w_s3  <= w_s2 + W_ONE;

			nx_s4   <= nx_s3[SUM_W-1] ? MAG_W'(-nx_s3) : MAG_W'(nx_s3);
			ny_s4   <= ny_s3[SUM_W-1] ? MAG_W'(-ny_s3) : MAG_W'(ny_s3);
			w_s4    <= w_s3[SUM_W-1] ? MAG_W'(-w_s3) : MAG_W'(w_s3);
			negx_s4 <= nx_s3[SUM_W-1] ^ w_s3[SUM_W-1];
			negy_s4 <= ny_s3[SUM_W-1] ^ w_s3[SUM_W-1];
			zero_s4 <= (w_s3 == '0);
		end
	end

	// Each divider step produces one quotient bit, most significant first.
	for (genvar i = 0; i < QW; i++) begin : g_div
		logic [MAG_W-1:0] rx_in, ry_in, den_in;
		logic [QW-1:0]    qx_in, qy_in;
		logic             negx_in, negy_in, zero_in, vld_in;
		logic [MAG_W:0]   stx, sty;

		if (i == 0) begin : g_first
			assign rx_in   = nx_s4;
			assign ry_in   = ny_s4;
			assign den_in  = w_s4;
			assign qx_in   = '0;
			assign qy_in   = '0;
			assign negx_in = negx_s4;
			assign negy_in = negy_s4;
			assign zero_in = zero_s4;
			assign vld_in  = vld_s4;
		end else begin : g_next
			assign rx_in   = rx_s[i-1];
			assign ry_in   = ry_s[i-1];
			assign den_in  = den_s[i-1];
			assign qx_in   = qx_s[i-1];
			assign qy_in   = qy_s[i-1];
			assign negx_in = negx_s[i-1];
			assign negy_in = negy_s[i-1];
			assign zero_in = zero_s[i-1];
			assign vld_in  = dv_vld_s[i-1];
		end

		assign stx = div_step(rx_in, den_in, QW - 1 - i);
		assign sty = div_step(ry_in, den_in, QW - 1 - i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[i] <= 1'b0;
			end else if (adv) begin
				dv_vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rx_s[i]   <= stx[MAG_W-1:0];
				ry_s[i]   <= sty[MAG_W-1:0];
				den_s[i]  <= den_in;
				qx_s[i]   <= {qx_in[QW-2:0], stx[MAG_W]};
				qy_s[i]   <= {qy_in[QW-2:0], sty[MAG_W]};
				negx_s[i] <= negx_in;
				negy_s[i] <= negy_in;
				zero_s[i] <= zero_in;
			end
		end
	end

	always_comb begin
		fx = sat_quot(qx_s[QW-1], negx_s[QW-1] && (qx_s[QW-1] != '0));
		fy = sat_quot(qy_s[QW-1], negy_s[QW-1] && (qy_s[QW-1] != '0));
		if (zero_s[QW-1]) begin
			res_d.screen_x = '0;
			res_d.screen_y = '0;
			res_d.status   = ST_ZERO;
		end else begin
			res_d.screen_x = fx[SCR_W-1:0];
			res_d.screen_y = fy[SCR_W-1:0];
			res_d.status   = (fx[SCR_W] || fy[SCR_W]) ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s23 <= res_d;
		end
	end

`ifndef SYNTH
	a_zero_outputs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == ST_ZERO) |->
		(out_data.screen_x == '0 && out_data.screen_y == '0))
		else $error("zero-denominator result carries non-zero coordinates");

	a_sat_on_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == ST_SAT) |->
		(out_data.screen_x == SCR_HI || out_data.screen_x == SCR_LO ||
		 out_data.screen_y == SCR_HI || out_data.screen_y == SCR_LO))
		else $error("saturated result has no coordinate on a rail");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(dv_vld_s) && $stable(vld_s1) && $stable(vld_s2) &&
		$stable(vld_s3) && $stable(vld_s4)))
		else $error("pipeline valid bits moved during a stall");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_s1)
		else $error("accepted transaction did not enter the first stage");
`endif

endmodule

/* test/testbench.sv */
// Self-checking bench for homography_point_transform: random and directed camera points
// under changing coefficient sets, with results checked against an exact projection.
// Depends on hpt_pkg and the block itself.
`timescale 1ns / 1ps

module testbench;
	import hpt_pkg::*;

	localparam longint ONE_FX     = longint'(1) << FRAC_BITS;
	localparam longint HALF_FX    = ONE_FX / 2;
	localparam int     IDLE_LIMIT = 2000;
	localparam int     HOLD_LEN   = 300;
	localparam int     DRAIN_WAIT = 30;
	localparam int     PHASE_PTS  = 165;
	localparam int     MAX_COORD  = (1 << COORD_BITS) - 1;

	typedef enum int {MIX_AFFINE, MIX_PERSPECTIVE, MIX_ZERO_LINE, MIX_WIDE} mix_t;
	typedef enum int {RX_OPEN, RX_COIN, RX_THIRD, RX_RARE} rx_style_t;

	class point_board;
		logic signed [COEF_W-1:0] coef [NUM_COEFS];
		point_out_t screen_q [$];
		int errors;

		function new();
			foreach (coef[i]) coef[i] = '0;
			coef[COEF_XX] = 48'sd1 <<< FRAC_BITS;
			coef[COEF_YY] = 48'sd1 <<< FRAC_BITS;
			errors = 0;
		endfunction

		function void set_coef(coef_idx_t idx, logic [COEF_W-1:0] value);
			coef[idx] = value;
		endfunction

		function int pending();
			return screen_q.size();
		endfunction

		function logic signed [SCR_W-1:0] clamp16(logic signed [79:0] q);
			if (q > 32767)
				return 16'sh7fff;
			if (q < -32768)
				return 16'sh8000;
			return q[SCR_W-1:0];
		endfunction

		function point_out_t project(point_in_t p);
			logic signed [79:0] c [NUM_COEFS];
			logic signed [79:0] px, py, one, nx, ny, w, qx, qy;
			point_out_t r;
			foreach (c[i]) c[i] = coef[i];
			px = p.cam_x;
			py = p.cam_y;
			one = 80'sd1 <<< FRAC_BITS;
			nx = c[COEF_XX] * px + c[COEF_XY] * py + c[COEF_XT];
			ny = c[COEF_YX] * px + c[COEF_YY] * py + c[COEF_YT];
			w  = c[COEF_WX] * px + c[COEF_WY] * py + one;
			r = '0;
			if (w == 0) begin
				r.status = ST_ZERO;
			end else begin
				qx = nx / w;
				qy = ny / w;
				r.screen_x = clamp16(qx);
				r.screen_y = clamp16(qy);
				if (qx > 32767 || qx < -32768 || qy > 32767 || qy < -32768)
					r.status = ST_SAT;
				else
					r.status = ST_OK;
			end
			return r;
		endfunction

		function void note_point(point_in_t p);
			screen_q = {screen_q, project(p)};
		endfunction

		function void check_screen(point_out_t got);
			point_out_t want;
			if (screen_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result (%0d, %0d, status %0d)", $time,
					got.screen_x, got.screen_y, got.status);
				return;
			end
			want = screen_q.pop_front();
			if (got.screen_x !== want.screen_x) begin
				errors++;
				$display("%0t: screen_x expected %0d, got %0d", $time,
					want.screen_x, got.screen_x);
			end
			if (got.screen_y !== want.screen_y) begin
				errors++;
				$display("%0t: screen_y expected %0d, got %0d", $time,
					want.screen_y, got.screen_y);
			end
			if (got.status !== want.status) begin
				errors++;
				$display("%0t: status expected %0d, got %0d", $time,
					want.status, got.status);
			end
		endfunction
	endclass

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	point_in_t         in_data   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	point_out_t        out_data;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	coef_idx_t         cfg_index = COEF_XX;
	logic [COEF_W-1:0] cfg_data  = '0;

	point_board        board = new();
	logic [COEF_W-1:0] mat [NUM_COEFS];
	int                burst_left = 1;
	bit                steady = 1'b0;
	bit                hold_req = 1'b0;
	int                zero_slope = 0;

	homography_point_transform uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (cfg_valid && cfg_ready)
			board.set_coef(cfg_index, cfg_data);
		if (in_valid && in_ready)
			board.note_point(in_data);
		if (out_valid && out_ready)
			board.check_screen(out_data);
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
		$display("tb: failure");
		$finish;
	end

	initial begin
		int cyc;
		rx_style_t style;
		cyc = 0;
		style = RX_OPEN;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
				hold_req = 1'b0;
			end
			if (cyc % 50 == 0)
				style = rx_style_t'($urandom_range(0, 3));
			cyc++;
			case (style)
				RX_OPEN:  out_ready = 1'b1;
				RX_COIN:  out_ready = 1'($urandom_range(0, 1));
				RX_THIRD: out_ready = (cyc % 3 == 0);
				default:  out_ready = ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	function automatic logic [COEF_W-1:0] fx(longint v);
		return v[COEF_W-1:0];
	endfunction

	function automatic longint srand(longint span);
		bit [63:0] u;
		u = {$urandom, $urandom};
		return longint'(u % (2 * span + 1)) - span;
	endfunction

	function automatic point_in_t random_point(mix_t mix);
		point_in_t p;
		int sel;
		sel = $urandom_range(0, 15);
		p.cam_x = COORD_BITS'($urandom);
		p.cam_y = COORD_BITS'($urandom);
		if (sel == 0) begin
			p.cam_x = COORD_BITS'($urandom_range(0, 1) ? MAX_COORD : 0);
			p.cam_y = COORD_BITS'($urandom_range(0, 1) ? MAX_COORD : 0);
		end else if (mix == MIX_ZERO_LINE && sel < 6) begin
			if (zero_slope == 0) begin
				p.cam_x = COORD_BITS'(1);
			end else begin
				p.cam_y = COORD_BITS'($urandom_range(0, (MAX_COORD - 1) / zero_slope));
				p.cam_x = COORD_BITS'(1 + zero_slope * p.cam_y);
			end
		end
		return p;
	endfunction

	task automatic pace();
		int gap;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			gap = steady ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				@(negedge clk) in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic offer(int x, int y);
		@(negedge clk);
		in_valid = 1'b1;
		in_data.cam_x = COORD_BITS'(x);
		in_data.cam_y = COORD_BITS'(y);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pace();
	endtask

	task automatic close_phase();
		@(negedge clk) in_valid = 1'b0;
		while (board.pending() != 0) @(negedge clk);
	endtask

	task automatic program_matrix();
		close_phase();
		for (int i = 0; i < NUM_COEFS; i++) begin
			@(negedge clk);
			cfg_valid = 1'b1;
			cfg_index = coef_idx_t'(i);
			cfg_data = mat[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		@(negedge clk) cfg_valid = 1'b0;
	endtask

	task automatic set_identity();
		foreach (mat[i]) mat[i] = '0;
		mat[COEF_XX] = fx(ONE_FX);
		mat[COEF_YY] = fx(ONE_FX);
	endtask

	task automatic choose_matrix(mix_t mix);
		mat[COEF_XX] = fx(srand(8 * ONE_FX));
		mat[COEF_XY] = fx(srand(2 * ONE_FX));
		mat[COEF_XT] = fx(srand(20000 * ONE_FX));
		mat[COEF_YX] = fx(srand(2 * ONE_FX));
		mat[COEF_YY] = fx(srand(8 * ONE_FX));
		mat[COEF_YT] = fx(srand(20000 * ONE_FX));
		mat[COEF_WX] = '0;
		mat[COEF_WY] = '0;
		case (mix)
			MIX_PERSPECTIVE: begin
				mat[COEF_WX] = fx(srand(ONE_FX >> 11));
				mat[COEF_WY] = fx(srand(ONE_FX >> 11));
			end
			MIX_ZERO_LINE: begin
				zero_slope = $urandom_range(0, 3);
				mat[COEF_WX] = fx(-ONE_FX);
				mat[COEF_WY] = fx(zero_slope * ONE_FX);
			end
			MIX_WIDE: begin
				foreach (mat[i]) mat[i] = COEF_W'({$urandom, $urandom});
			end
			default: ;
		endcase
	endtask

	initial begin
		point_in_t p;
		mix_t mix;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Reset coefficients give the identity mapping.
		offer(0, 0);
		offer(MAX_COORD, MAX_COORD);
		offer(MAX_COORD, 0);
		offer(0, MAX_COORD);
		offer(1, 2);

		foreach (mat[i]) mat[i] = 48'h7fff_ffff_ffff;
		program_matrix();
		offer(0, 0);
		offer(1, 0);
		offer(MAX_COORD, MAX_COORD);

		foreach (mat[i]) mat[i] = 48'h8000_0000_0000;
		program_matrix();
		offer(0, 0);
		offer(MAX_COORD, 0);
		offer(MAX_COORD, MAX_COORD);

		// Translations just inside and just outside the output range.
		set_identity();
		mat[COEF_XT] = fx(32767 * ONE_FX + HALF_FX);
		mat[COEF_YT] = fx(-(32768 * ONE_FX));
		mat[COEF_YY] = fx(-ONE_FX);
		program_matrix();
		offer(0, 0);
		offer(1, 0);
		offer(0, 1);
		offer(MAX_COORD, MAX_COORD);

		// Denominator 1 - x: zero at x = 1 and negative beyond it.
		set_identity();
		mat[COEF_XT] = fx(3 * ONE_FX);
		mat[COEF_YT] = fx(-5 * ONE_FX);
		mat[COEF_WX] = fx(-ONE_FX);
		program_matrix();
		offer(1, 7);
		offer(0, 0);
		offer(3, 9);
		offer(2, 0);
		offer(MAX_COORD, 0);

		foreach (mat[i]) mat[i] = '0;
		mat[COEF_XY] = fx(ONE_FX);
		mat[COEF_YX] = fx(ONE_FX);
		mat[COEF_WX] = fx(ONE_FX / 4);
		mat[COEF_WY] = fx(ONE_FX / 4);
		program_matrix();
		offer(8, 4);
		offer(MAX_COORD, 1);

		for (int ph = 0; ph < 8; ph++) begin
			mix = mix_t'(ph % 4);
			steady = (ph == 2 || ph == 5);
			choose_matrix(mix);
			program_matrix();
			if (ph == 1)
				hold_req = 1'b1;
			repeat (PHASE_PTS) begin
				p = random_point(mix);
				offer(p.cam_x, p.cam_y);
			end
		end

		close_phase();
		repeat (DRAIN_WAIT) @(negedge clk);
		if (board.pending() != 0) begin
			board.errors++;
			$display("%0t: %0d results never arrived", $time, board.pending());
		end
		if (board.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
